// ----- rtl/itrd_pkg.sv -----
package itrd_pkg;

    // Default conversion width
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths
    localparam int IN_VALUE_W = 32;
    localparam int BASE_W     = 8;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 6;

    // Character and radix constants
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_ALPHA  = 8'h41;
    localparam logic [CHAR_W-1:0]  CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0]  CH_NONE   = 8'h00;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;
    localparam logic [BASE_W-1:0]  MIN_BASE  = 8'd2;
    localparam logic [BASE_W-1:0]  MAX_BASE  = 8'd36;

    typedef struct packed {
        logic signed [IN_VALUE_W-1:0] value;
        logic [BASE_W-1:0]            base;
        logic                         func;
    } req_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              base_error;
        logic              last;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ERR,
        S_SIGN,
        S_RD,
        S_EMIT
    } state_t;

    // Digit value 0..35 to ASCII
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_LIMIT)
        begin
            return CH_ZERO + dx;
        end
        return CH_ALPHA + dx - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_LIMIT};
    endfunction

endpackage

// ----- rtl/itrd_ram.sv -----
module itrd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/integer_to_radix_digits.sv -----
// Bit-serial restoring division, one remainder bit per cycle, produces the N digits
//   of the result; then each character is read out of the digit RAM (S_RD, S_EMIT),
//   after a minus sign (S_SIGN) if the value is negative. A bad base goes through
//   S_ERR to its error item.
// Throughput: one item at a time; the next item is accepted after the last character.
// Reset: rst_n is asynchronous, active low; it clears the sequencer and output valid.
module integer_to_radix_digits #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  itrd_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output itrd_pkg::rsp_item_t rsp
);

    import itrd_pkg::*;

    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W = $clog2(VALUE_BITS);

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [DIGIT_W-1:0]      base_reg, base_next;
    logic                    neg_reg, neg_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [CNT_W-1:0]        ndig_reg, ndig_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_reg, rsp_next;

    logic [VALUE_BITS-1:0]   in_val;
    logic [VALUE_BITS-1:0]   in_mag;
    logic                    in_neg;
    logic                    base_ok;
    logic [DIGIT_W:0]        part_rem;
    logic [DIGIT_W:0]        part_diff;
    logic                    q_bit;
    logic [DIGIT_W-1:0]      step_rem;
    logic [VALUE_BITS-1:0]   step_val;
    logic [CNT_W-1:0]        ptr_m1;
    logic                    load_ok;
    logic                    ram_wr;
    logic                    ram_rd;
    logic [DIGIT_W-1:0]      ram_q;

    // Fit the input value to the conversion width
    generate
        if (VALUE_BITS <= IN_VALUE_W)
        begin : g_trunc
            assign in_val = req.value[VALUE_BITS-1:0];
        end
        else
        begin : g_ext
            assign in_val = {{(VALUE_BITS-IN_VALUE_W){req.value[IN_VALUE_W-1]}}, req.value};
        end
    endgenerate

    assign in_neg  = !req.func && in_val[VALUE_BITS-1];
    assign in_mag  = in_neg ? (~in_val + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_val;
    assign base_ok = (req.base >= MIN_BASE) && (req.base <= MAX_BASE);

    // One restoring division step: remainder takes the value's top bit
    assign part_rem  = {rem_reg, val_reg[VALUE_BITS-1]};
    assign q_bit     = part_rem >= {1'b0, base_reg};
    assign part_diff = part_rem - {1'b0, base_reg};
    assign step_rem  = q_bit ? part_diff[DIGIT_W-1:0] : part_rem[DIGIT_W-1:0];
    assign step_val  = {val_reg[VALUE_BITS-2:0], q_bit};

    assign ptr_m1  = ndig_reg - {{(CNT_W-1){1'b0}}, 1'b1};
    assign load_ok = !rsp_valid_reg || rsp_ready;

    // Digit stack, written least significant first, read back in reverse
    itrd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (ndig_reg[ADDR_W-1:0]),
        .wr_data (step_rem),
        .rd_en   (ram_rd),
        .rd_addr (ptr_m1[ADDR_W-1:0]),
        .rd_data (ram_q)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        neg_reg  <= neg_next;
        bit_reg  <= bit_next;
        ndig_reg <= ndig_next;
        rsp_reg  <= rsp_next;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        bit_next       = bit_reg;
        ndig_next      = ndig_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        ram_wr         = 1'b0;
        ram_rd         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    val_next  = in_mag;
                    neg_next  = in_neg;
                    base_next = req.base[DIGIT_W-1:0];
                    rem_next  = '0;
                    bit_next  = '0;
                    ndig_next = '0;
                    state_next = base_ok ? S_DIV : S_ERR;
                end
            end

            S_DIV:
            begin
                val_next = step_val;
                rem_next = step_rem;
                bit_next = bit_reg + {{(BIT_W-1){1'b0}}, 1'b1};
                if (bit_reg == BIT_W'(VALUE_BITS - 1))
                begin
                    // Digit done: push it, restart on the quotient
                    ram_wr    = 1'b1;
                    ndig_next = ndig_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    rem_next  = '0;
                    bit_next  = '0;
                    if (step_val == '0)
                    begin
                        state_next = neg_reg ? S_SIGN : S_RD;
                    end
                end
            end

            S_ERR:
            begin
                if (load_ok)
                begin
                    rsp_next.char_code  = CH_NONE;
                    rsp_next.base_error = 1'b1;
                    rsp_next.last       = 1'b1;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_SIGN:
            begin
                if (load_ok)
                begin
                    rsp_next.char_code  = CH_MINUS;
                    rsp_next.base_error = 1'b0;
                    rsp_next.last       = 1'b0;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_RD;
                end
            end

            S_RD:
            begin
                ram_rd     = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (load_ok)
                begin
                    rsp_next.char_code  = digit_char(ram_q);
                    rsp_next.base_error = 1'b0;
                    rsp_next.last       = (ptr_m1 == '0);
                    rsp_valid_next      = 1'b1;
                    ndig_next           = ptr_m1;
                    state_next          = (ptr_m1 == '0) ? S_IDLE : S_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Error items carry no character and close the conversion
    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.base_error |-> rsp.last && (rsp.char_code == CH_NONE))
        else $error("error item malformed");

    // Digit stack never overflows while a conversion runs
    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> ndig_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count out of range");

    // Partial remainder stays below the base throughout a division
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < base_reg)
        else $error("remainder not reduced");

    // A bad base goes straight to the error item
    a_bad_base: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !base_ok |=> state_reg == S_ERR)
        else $error("bad base not flagged");

endmodule

// ----- tb/sv/integer_to_radix_digits_test.sv -----
`timescale 1ns / 1ps

module integer_to_radix_digits_test;
    import itrd_pkg::*;

    localparam int CONV_BITS    = VALUE_BITS_DEF;
    localparam int DRAIN_CYCLES = 100;

    typedef enum int
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_RUNS
    } ready_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    // Characters still owed by the block, oldest first
    rsp_item_t   pending_chars[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          bad_base_items = 0;
    int          chars_checked = 0;
    bit [36:0]   bases_hit = '0;
    int          burst_left = 1;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_cycle = 0;
    int          stall_left = 0;

    integer_to_radix_digits u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Digit string of one item: optional minus, digits MSB first, last on the final one
    function automatic void predict_digits(input req_item_t it);
        logic [CONV_BITS-1:0] mag;
        logic [7:0]           digs[$];
        int unsigned          radix;
        bit                   neg;
        rsp_item_t            ch;

        radix = {24'd0, it.base};
        if (it.base < MIN_BASE || it.base > MAX_BASE)
        begin
            ch.char_code = CH_NONE;
            ch.base_error = 1'b1;
            ch.last = 1'b1;
            pending_chars.push_back(ch);
            bad_base_items++;
            return;
        end
        bases_hit[radix] = 1'b1;
        mag = it.value[CONV_BITS-1:0];
        neg = !it.func && mag[CONV_BITS-1];
        if (neg)
        begin
            mag = -mag;
            ch.char_code = CH_MINUS;
            ch.base_error = 1'b0;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        do
        begin
            digs.push_front(8'(mag % radix));
            mag = mag / radix;
        end
        while (mag != 0);
        foreach (digs[i])
        begin
            if (digs[i] < 8'(DEC_LIMIT))
                ch.char_code = CH_ZERO + digs[i];
            else
                ch.char_code = CH_ALPHA + (digs[i] - 8'(DEC_LIMIT));
            ch.base_error = 1'b0;
            ch.last = (i == digs.size() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Present one item, hold it until taken, then maybe end the burst with a gap
    task automatic send_item(input logic [31:0] value, input logic [7:0] base,
                             input logic func);
        req_item_t it;
        int        gap;

        it.value = value;
        it.base = base;
        it.func = func;
        req_valid <= 1'b1;
        req <= it;
        do
            @(posedge clk);
        while (!req_ready);
        predict_digits(it);
        items_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Receiver: picks among three stall patterns at random
    always @(posedge clk)
    begin
        ready_cycle++;
        if (ready_cycle % 256 == 0)
            ready_mode = ready_mode_t'($urandom_range(0, 2));
        case (ready_mode)
            READY_ALWAYS:
                rsp_ready <= 1'b1;
            READY_RANDOM:
                rsp_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left == 0)
                begin
                    rsp_ready <= 1'b1;
                    stall_left = $urandom_range(1, 10);
                end
                else
                begin
                    rsp_ready <= 1'b0;
                    stall_left--;
                end
            end
        endcase
    end

    // Compare each accepted character with the oldest one owed
    always @(posedge clk)
    begin
        rsp_item_t want;

        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("char_code: no character pending, actual %h", rsp.char_code);
                mismatches++;
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (rsp.char_code !== want.char_code)
                begin
                    $error("char_code: expected %h, actual %h", want.char_code,
                           rsp.char_code);
                    mismatches++;
                end
                if (rsp.base_error !== want.base_error)
                begin
                    $error("base_error: expected %b, actual %b", want.base_error,
                           rsp.base_error);
                    mismatches++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, rsp.last);
                    mismatches++;
                end
            end
        end
    end

    // Zero converts to a single '0' in bases 10, 2 and 36, in both modes
    task automatic test_zero();
        send_item(32'd0, 8'd10, 1'b0);
        send_item(32'd0, 8'd2, 1'b1);
        send_item(32'd0, 8'd36, 1'b0);
    endtask

    // Widest strings and the most negative value
    task automatic test_extremes();
        send_item(32'h7FFF_FFFF, 8'd2, 1'b0);
        send_item(32'h8000_0000, 8'd2, 1'b0);
        send_item(32'h8000_0000, 8'd10, 1'b0);
        send_item(32'h8000_0000, 8'd16, 1'b1);
        send_item(32'hFFFF_FFFF, 8'd2, 1'b1);
        send_item(32'hFFFF_FFFF, 8'd16, 1'b0);
        send_item(32'hFFFF_FFFF, 8'd36, 1'b1);
        send_item(32'h7FFF_FFFF, 8'd36, 1'b0);
    endtask

    // Boundary between numeric and letter digits
    task automatic test_letter_digits();
        send_item(32'd35, 8'd36, 1'b0);
        send_item(32'd10, 8'd11, 1'b0);
        send_item(-32'sd35, 8'd36, 1'b0);
        send_item(32'd1295, 8'd36, 1'b1);
        send_item(32'd9, 8'd10, 1'b0);
    endtask

    // Radix outside 2..36 gives one error item
    task automatic test_bad_base();
        send_item(32'd123, 8'd0, 1'b0);
        send_item(-32'sd5, 8'd1, 1'b1);
        send_item(32'd0, 8'd37, 1'b0);
        send_item(32'h8000_0000, 8'd255, 1'b1);
        send_item(32'd7, 8'h80, 1'b0);
    endtask

    // Random mix of radixes, magnitudes, signs and modes
    task automatic test_random(input int count);
        logic [31:0] value;
        logic [7:0]  base;

        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                base = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1))
                                                   : 8'($urandom_range(37, 255));
            else
                base = 8'($urandom_range(2, 36));
            case ($urandom_range(0, 3))
                0: value = $urandom;
                1: value = $urandom >> $urandom_range(0, 31);
                2: value = $urandom_range(0, 40);
                default: value = -$urandom_range(1, 40);
            endcase
            send_item(value, base, 1'(($urandom_range(0, 1))));
        end
    endtask

    // Let the block finish everything owed, then watch for stray characters
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero();
        test_extremes();
        test_letter_digits();
        test_bad_base();
        test_random(500);
        drain();
        if (pending_chars.size() != 0)
        begin
            $error("char_code: %0d characters never arrived", pending_chars.size());
            mismatches++;
        end
        $display("Covered %0d conversions (%0d with a bad radix), %0d characters checked,",
                 items_sent, bad_base_items, chars_checked);
        $display("%0d distinct valid radixes, both modes, three receiver stall patterns.",
                 $countones(bases_hit));
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
